// ===== src/omt_pkg.sv =====
// Shared types and constants for the one-to-one map table.
// No dependencies; the interfaces, engine, top level and testbench take names from here.
`default_nettype none

package omt_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KIND_W   = 3;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;
   localparam int CMP_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int PAIR_W   = 2 * DATA_W;

   localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CONFLICT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EXISTS   = 3'd1,
      ST_CONFLICT = 3'd2,
      ST_FULL     = 3'd3,
      ST_MISS     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_READ = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] key_out;
      logic signed [DATA_W-1:0] value_out;
      logic [COUNT_W-1:0]       entry_count;
   } res_type;

endpackage

`default_nettype wire

// ===== src/omt_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on omt_pkg for field widths.
`default_nettype none

interface omt_req_if;
   logic                             valid;
   logic                             ready;
   logic [omt_pkg::KIND_W-1:0]       kind;
   logic signed [omt_pkg::DATA_W-1:0] key;
   logic signed [omt_pkg::DATA_W-1:0] value;
   logic [omt_pkg::IDX_W-1:0]        entry_index;
   logic signed [omt_pkg::DATA_W-1:0] default_value;

   modport source (output valid, kind, key, value, entry_index, default_value,
                   input ready);
   modport sink   (input valid, kind, key, value, entry_index, default_value,
                   output ready);
endinterface

interface omt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [omt_pkg::STATUS_W-1:0]     status;
   logic signed [omt_pkg::DATA_W-1:0] key_out;
   logic signed [omt_pkg::DATA_W-1:0] value_out;
   logic [omt_pkg::COUNT_W-1:0]      entry_count;

   modport source (output valid, status, key_out, value_out, entry_count,
                   input ready);
   modport sink   (input valid, status, key_out, value_out, entry_count,
                   output ready);
endinterface

`default_nettype wire

// ===== src/omt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module omt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/omt_engine.sv =====
// Request sequencer: scans the pair store, decides status, appends pairs.
// Depends on omt_pkg and omt_if; drives the pair RAM in the top level.
`default_nettype none

module omt_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   omt_req_if.sink                            req_chan,
   output logic                               wr_en,
   output logic [omt_pkg::ADDR_W-1:0]         wr_addr,
   output logic [omt_pkg::PAIR_W-1:0]         wr_data,
   output logic [omt_pkg::ADDR_W-1:0]         rd_addr,
   input  wire logic [omt_pkg::PAIR_W-1:0]    rd_data,
   output logic                               res_valid,
   output omt_pkg::res_type                   res,
   input  wire logic                          res_take
);

   omt_pkg::state_type state_ff, state_in;
   logic [omt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [omt_pkg::CNT_W-1:0]  issue_ff, issue_in;
   logic                       rd_vld_ff, rd_vld_in;

   logic [omt_pkg::KIND_W-1:0]        kind_ff, kind_in;
   logic signed [omt_pkg::DATA_W-1:0] key_ff, key_in;
   logic signed [omt_pkg::DATA_W-1:0] value_ff, value_in;
   logic signed [omt_pkg::DATA_W-1:0] dflt_ff, dflt_in;

   omt_pkg::status_type               status_ff, status_in;
   logic signed [omt_pkg::DATA_W-1:0] key_out_ff, key_out_in;
   logic signed [omt_pkg::DATA_W-1:0] value_out_ff, value_out_in;

   logic                              accept;
   logic signed [omt_pkg::DATA_W-1:0] ram_key;
   logic signed [omt_pkg::DATA_W-1:0] ram_value;
   logic                              key_hit;
   logic                              value_hit;
   logic                              issue_more;
   logic                              idx_in_range;

   assign req_chan.ready = (state_ff == omt_pkg::S_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;

   assign ram_key    = rd_data[omt_pkg::PAIR_W-1:omt_pkg::DATA_W];
   assign ram_value  = rd_data[omt_pkg::DATA_W-1:0];
   assign key_hit    = (ram_key == key_ff);
   assign value_hit  = (ram_value == value_ff);
   assign issue_more = (issue_ff < count_ff);
   assign idx_in_range = (omt_pkg::CMP_W'(req_chan.entry_index)
                          < omt_pkg::CMP_W'(count_ff));

   assign wr_addr = count_ff[omt_pkg::ADDR_W-1:0];
   assign wr_data = {key_ff, value_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      dflt_in      = dflt_ff;
      status_in    = status_ff;
      key_out_in   = key_out_ff;
      value_out_in = value_out_ff;
      wr_en        = 1'b0;
      rd_addr      = issue_ff[omt_pkg::ADDR_W-1:0];

      case (state_ff)
         omt_pkg::S_IDLE: begin
            rd_addr = omt_pkg::ADDR_W'(req_chan.entry_index);
            if (accept) begin
               kind_in      = req_chan.kind;
               key_in       = req_chan.key;
               value_in     = req_chan.value;
               dflt_in      = req_chan.default_value;
               issue_in     = '0;
               status_in    = omt_pkg::ST_OK;
               key_out_in   = '0;
               value_out_in = '0;
               case (req_chan.kind)
                  omt_pkg::KIND_ADD, omt_pkg::KIND_LOOKUP,
                  omt_pkg::KIND_CONFLICT: begin
                     state_in = omt_pkg::S_SCAN;
                  end
                  omt_pkg::KIND_READ: begin
                     if (idx_in_range) begin
                        state_in = omt_pkg::S_READ;
                     end else begin
                        status_in = omt_pkg::ST_MISS;
                        state_in  = omt_pkg::S_DONE;
                     end
                  end
                  omt_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     state_in = omt_pkg::S_DONE;
                  end
                  default: begin
                     state_in = omt_pkg::S_DONE;
                  end
               endcase
            end
         end

         omt_pkg::S_SCAN: begin
            if (issue_more) begin
               issue_in  = issue_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && kind_ff == omt_pkg::KIND_ADD && key_hit && value_hit) begin
               status_in = omt_pkg::ST_EXISTS;
               state_in  = omt_pkg::S_DONE;
            end else if (rd_vld_ff && kind_ff != omt_pkg::KIND_LOOKUP
                         && (key_hit ^ value_hit)) begin
               status_in = omt_pkg::ST_CONFLICT;
               state_in  = omt_pkg::S_DONE;
            end else if (rd_vld_ff && kind_ff == omt_pkg::KIND_LOOKUP && key_hit) begin
               status_in    = omt_pkg::ST_OK;
               value_out_in = ram_value;
               state_in     = omt_pkg::S_DONE;
            end else if (!rd_vld_ff && !issue_more) begin
               state_in = omt_pkg::S_DONE;
               case (kind_ff)
                  omt_pkg::KIND_ADD: begin
                     if (count_ff == omt_pkg::CNT_W'(omt_pkg::CAPACITY)) begin
                        status_in = omt_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  omt_pkg::KIND_LOOKUP: begin
                     status_in    = omt_pkg::ST_MISS;
                     value_out_in = dflt_ff;
                  end
                  default: begin
                     status_in = omt_pkg::ST_OK;
                  end
               endcase
            end
         end

         omt_pkg::S_READ: begin
            key_out_in   = ram_key;
            value_out_in = ram_value;
            state_in     = omt_pkg::S_DONE;
         end

         omt_pkg::S_DONE: begin
            if (res_take) begin
               state_in = omt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = omt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= omt_pkg::S_IDLE;
         count_ff  <= '0;
         issue_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      dflt_ff      <= dflt_in;
      status_ff    <= status_in;
      key_out_ff   <= key_out_in;
      value_out_ff <= value_out_in;
   end

   assign res_valid       = (state_ff == omt_pkg::S_DONE);
   assign res.status      = status_ff;
   assign res.key_out     = key_out_ff;
   assign res.value_out   = value_out_ff;
   assign res.entry_count = omt_pkg::COUNT_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= omt_pkg::CNT_W'(omt_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_append_bumps: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == omt_pkg::CNT_W'($past(count_ff) + 1'b1))
      else $error("append did not advance entry count");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != omt_pkg::S_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_take |=> res_valid && $stable(status_ff)
                                 && $stable(value_out_ff))
      else $error("pending result changed before handoff");
`endif

endmodule

`default_nettype wire

// ===== src/one_to_one_map_table_top.sv =====
// Add, lookup and conflict check scan the stored pairs and can finish early on a hit;
// read entry goes through a single RAM read, and clear and unused kinds skip the RAM.
// One request is in flight at a time; the scan of the pair RAM, one entry per cycle,
// sets the rate.
// Reset clears the entry count and control only; the pair RAM is not swept.
// Top level: pair RAM, request sequencer and response register. Uses omt_pkg, omt_if.
`default_nettype none

module one_to_one_map_table_top (
   input  wire logic  clock,
   input  wire logic  reset,
   omt_req_if.sink    req_chan,
   omt_rsp_if.source  rsp_chan
);

   logic                        wr_en;
   logic [omt_pkg::ADDR_W-1:0]  wr_addr;
   logic [omt_pkg::PAIR_W-1:0]  wr_data;
   logic [omt_pkg::ADDR_W-1:0]  rd_addr;
   logic [omt_pkg::PAIR_W-1:0]  rd_data;
   logic                        res_valid;
   logic                        res_take;
   omt_pkg::res_type            res;

   logic                        rsp_valid_ff, rsp_valid_in;
   omt_pkg::res_type            rsp_ff;

   omt_ram #(
      .WIDTH (omt_pkg::PAIR_W),
      .DEPTH (omt_pkg::CAPACITY)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   omt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   assign res_take     = res_valid & (~rsp_valid_ff | rsp_chan.ready);
   assign rsp_valid_in = res_take | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.key_out     = rsp_ff.key_out;
   assign rsp_chan.value_out   = rsp_ff.value_out;
   assign rsp_chan.entry_count = rsp_ff.entry_count;

endmodule

`default_nettype wire

// ===== verif/one_to_one_map_table_top_tb.sv =====
// Self-checking testbench for one_to_one_map_table_top: directed and random requests
// go through a scoreboard that predicts every response, with random idling on both sides.
// Depends on omt_pkg and the omt_req_if / omt_rsp_if interfaces.
`default_nettype none

module one_to_one_map_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import omt_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int DRAIN_CYCLES = 80;
   localparam int LIMIT_NS     = 10_000_000;
   localparam int POOL_N       = 16;
   localparam int MAX_PRINTS   = 40;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

   logic clock;
   logic reset;

   omt_req_if req_chan ();
   omt_rsp_if rsp_chan ();

   one_to_one_map_table_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic signed [DATA_W-1:0] map_keys [CAPACITY];
   logic signed [DATA_W-1:0] map_vals [CAPACITY];
   logic [DATA_W-1:0]        word_pool [POOL_N];
   int                       map_count;
   int                       peak_count;
   res_type                  expected_q [$];

   int   send_idle_pct;
   int   rsp_idle_pct;
   logic hold_on;

   int errors;
   int requests_sent;
   int responses_seen;
   int status_tally [5];

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL one_to_one_map_table_top");
      $finish;
   end

   function automatic status_type scan_clash(input logic [DATA_W-1:0] k,
                                             input logic [DATA_W-1:0] v,
                                             input bit exact_stops);
      int i;
      for (i = 0; i < map_count; i++) begin
         if (map_keys[i] == k && map_vals[i] == v) begin
            if (exact_stops) return ST_EXISTS;
         end else if (map_keys[i] == k || map_vals[i] == v) begin
            return ST_CONFLICT;
         end
      end
      return ST_OK;
   endfunction

   function automatic res_type apply_request(input logic [KIND_W-1:0] kind,
                                             input logic [DATA_W-1:0] k,
                                             input logic [DATA_W-1:0] v,
                                             input logic [IDX_W-1:0]  idx,
                                             input logic [DATA_W-1:0] dflt);
      res_type r;
      int      i;
      r.status    = ST_OK;
      r.key_out   = '0;
      r.value_out = '0;
      case (kind)
         KIND_ADD: begin
            r.status = scan_clash(k, v, 1'b1);
            if (r.status == ST_OK) begin
               if (map_count >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  map_keys[map_count] = k;
                  map_vals[map_count] = v;
                  map_count++;
               end
            end
         end
         KIND_LOOKUP: begin
            r.status    = ST_MISS;
            r.value_out = dflt;
            for (i = 0; i < map_count; i++) begin
               if (r.status == ST_MISS && map_keys[i] == k) begin
                  r.status    = ST_OK;
                  r.value_out = map_vals[i];
               end
            end
         end
         KIND_CONFLICT: begin
            r.status = scan_clash(k, v, 1'b0);
         end
         KIND_READ: begin
            if (int'(idx) < map_count) begin
               r.key_out   = map_keys[idx];
               r.value_out = map_vals[idx];
            end else begin
               r.status = ST_MISS;
            end
         end
         KIND_CLEAR: begin
            map_count = 0;
         end
         default: ;
      endcase
      r.entry_count = map_count[COUNT_W-1:0];
      if (map_count > peak_count) peak_count = map_count;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] exp);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("mismatch on response %0d, %s: got %h, expected %h",
                  responses_seen, what, got, exp);
   endtask

   task automatic check_response();
      res_type exp;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected response", rsp_chan.value_out, '0);
         return;
      end
      exp = expected_q.pop_front();
      if (rsp_chan.status !== exp.status)
         report_mismatch("status", DATA_W'(rsp_chan.status), DATA_W'(exp.status));
      if (rsp_chan.key_out !== exp.key_out)
         report_mismatch("key_out", rsp_chan.key_out, exp.key_out);
      if (rsp_chan.value_out !== exp.value_out)
         report_mismatch("value_out", rsp_chan.value_out, exp.value_out);
      if (rsp_chan.entry_count !== exp.entry_count)
         report_mismatch("entry_count", DATA_W'(rsp_chan.entry_count),
                         DATA_W'(exp.entry_count));
      if (int'(exp.status) < 5) status_tally[exp.status]++;
   endtask

   // Response side: check each accepted response, then pick ready for the next edge.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               responses_seen++;
               check_response();
            end
            rsp_chan.ready <= !hold_on && ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [DATA_W-1:0] k,
                               input logic [DATA_W-1:0] v,
                               input logic [IDX_W-1:0]  idx,
                               input logic [DATA_W-1:0] dflt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= kind;
      req_chan.key           <= k;
      req_chan.value         <= v;
      req_chan.entry_index   <= idx;
      req_chan.default_value <= dflt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_q.push_back(apply_request(kind, k, v, idx, dflt));
      requests_sent++;
   endtask

   task automatic add_pair(input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] v);
      send_request(KIND_ADD, k, v, IDX_W'($urandom_range(63)), $urandom);
   endtask

   task automatic lookup_key(input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] dflt);
      send_request(KIND_LOOKUP, k, $urandom, IDX_W'($urandom_range(63)), dflt);
   endtask

   task automatic check_pair(input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] v);
      send_request(KIND_CONFLICT, k, v, IDX_W'($urandom_range(63)), $urandom);
   endtask

   task automatic read_entry(input logic [IDX_W-1:0] idx);
      send_request(KIND_READ, $urandom, $urandom, idx, $urandom);
   endtask

   task automatic clear_table();
      send_request(KIND_CLEAR, $urandom, $urandom, IDX_W'($urandom_range(63)), $urandom);
   endtask

   function automatic logic [DATA_W-1:0] pick_word(input bit from_keys);
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 3 && map_count > 0)
         return from_keys ? map_keys[$urandom_range(map_count - 1)]
                          : map_vals[$urandom_range(map_count - 1)];
      if (sel < 6) return word_pool[$urandom_range(POOL_N - 1)];
      if (sel < 7) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   task automatic test_add_and_clash();
      read_entry(6'd0);
      add_pair(32'h8000_0000, 32'h7fff_ffff);
      add_pair(32'h7fff_ffff, 32'h8000_0000);
      add_pair(32'h0000_0000, 32'hffff_ffff);
      add_pair(32'hffff_ffff, 32'h0000_0000);
      add_pair(32'h0000_0000, 32'hffff_ffff);
      add_pair(32'h0000_0000, 32'h0000_0005);
      add_pair(32'h0000_0005, 32'hffff_ffff);
   endtask

   task automatic test_lookup();
      lookup_key(32'h7fff_ffff, $urandom);
      lookup_key(32'h0000_3039, 32'h7fff_ffff);
      lookup_key(32'h0000_3039, 32'h8000_0000);
   endtask

   task automatic test_conflict_check();
      check_pair(32'h0000_0000, 32'hffff_ffff);
      check_pair(32'h0000_0000, 32'h0000_0007);
      check_pair(32'h0000_0009, 32'h0000_0000);
      check_pair(32'h0000_0009, 32'h0000_000a);
   endtask

   task automatic test_read_entry();
      read_entry(6'd3);
      read_entry(6'd4);
      read_entry(6'd63);
   endtask

   task automatic test_clear_and_spare_kinds();
      send_request(KIND_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 6'd63, 32'hffff_ffff);
      send_request(KIND_SPARE_B, $urandom, $urandom, IDX_W'($urandom_range(63)), $urandom);
      send_request(KIND_SPARE_C, $urandom, $urandom, IDX_W'($urandom_range(63)), $urandom);
      clear_table();
      read_entry(6'd0);
      add_pair(32'ha5a5_a5a5, 32'h5a5a_5a5a);
   endtask

   task automatic test_full_table();
      logic [DATA_W-1:0] base_k;
      logic [DATA_W-1:0] base_v;
      int                i;
      base_k = $urandom;
      base_v = $urandom;
      clear_table();
      for (i = 0; i < CAPACITY; i++)
         add_pair({base_k[31:6], i[5:0]}, {base_v[31:6], i[5:0]});
      add_pair({~base_k[31:6], 6'd0}, {~base_v[31:6], 6'd0});
      add_pair({base_k[31:6], 6'd10}, {base_v[31:6], 6'd10});
      add_pair({base_k[31:6], 6'd5}, {~base_v[31:6], 6'd5});
      check_pair({~base_k[31:6], 6'd0}, {~base_v[31:6], 6'd0});
      read_entry(6'd63);
      lookup_key({base_k[31:6], 6'd63}, $urandom);
   endtask

   task automatic test_random(input int n);
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] k;
      logic [DATA_W-1:0] v;
      logic [IDX_W-1:0]  idx;
      int unsigned       r;
      int                pos;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 46)      kind = KIND_ADD;
         else if (r < 63) kind = KIND_LOOKUP;
         else if (r < 78) kind = KIND_CONFLICT;
         else if (r < 96) kind = KIND_READ;
         else if (r < 97) kind = KIND_CLEAR;
         else             kind = KIND_W'(KIND_SPARE_A + $urandom_range(2));
         k = pick_word(1'b1);
         v = pick_word(1'b0);
         // reuse a stored pair as a whole now and then
         if (map_count > 0 && $urandom_range(4) == 0) begin
            pos = $urandom_range(map_count - 1);
            k   = map_keys[pos];
            v   = map_vals[pos];
         end
         if (map_count > 0 && $urandom_range(1) == 0)
            idx = IDX_W'($urandom_range(map_count - 1));
         else
            idx = IDX_W'($urandom_range(63));
         send_request(kind, k, v, idx, $urandom);
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
         test_random(12);
      join
   endtask

   initial begin
      int i;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.kind          = '0;
      req_chan.key           = '0;
      req_chan.value         = '0;
      req_chan.entry_index   = '0;
      req_chan.default_value = '0;
      hold_on                = 1'b0;
      send_idle_pct          = 0;
      rsp_idle_pct           = 0;
      map_count              = 0;
      peak_count             = 0;
      errors                 = 0;
      requests_sent          = 0;
      responses_seen         = 0;
      for (i = 0; i < 5; i++) status_tally[i] = 0;
      for (i = 0; i < POOL_N; i++) word_pool[i] = (i < 6) ? i : $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      rsp_idle_pct  = 65;
      test_add_and_clash();
      test_lookup();
      test_conflict_check();
      test_read_entry();
      test_clear_and_spare_kinds();
      test_random(320);

      send_idle_pct = 65;
      rsp_idle_pct  = 31;
      test_full_table();
      test_random(320);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_backpressure();
      test_random(320);

      req_chan.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, %0d responses checked, table peaked at %0d entries.",
               requests_sent, responses_seen, peak_count);
      $display("Status mix: ok %0d, exists %0d, conflict %0d, full %0d, miss %0d.",
               status_tally[ST_OK], status_tally[ST_EXISTS], status_tally[ST_CONFLICT],
               status_tally[ST_FULL], status_tally[ST_MISS]);
      if (errors == 0) begin
         $display("PASS one_to_one_map_table_top");
      end else begin
         $display("FAIL one_to_one_map_table_top");
      end
      $finish;
   end

endmodule

`default_nettype wire
